// File: src/lssd_pkg.sv
// lssd_pkg: shared types and constants for the lsb stego stream decoder
// no dependencies; imported by every module of the block
package lssd_pkg;

	// frame layout
	localparam int unsigned HEADER_BYTES = 54;
	localparam int unsigned BYTE_BITS    = 8;
	localparam int unsigned WORD_BITS    = 32;
	localparam int unsigned MAGIC_MAX    = 8;

	// small queues between the parts
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAGIC_WORD   = 2'd0,
		CFG_MAGIC_LENGTH = 2'd1
	} cfg_idx_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_EXT_LEN   = 3'd0,
		KIND_EXT_BYTE  = 3'd1,
		KIND_FILE_SIZE = 3'd2,
		KIND_DATA_BYTE = 3'd3,
		KIND_MISMATCH  = 3'd4
	} kind_t;

	// decoder phases
	typedef enum logic [7:0] {
		PH_IDLE   = 8'b0000_0001,
		PH_HEADER = 8'b0000_0010,
		PH_MAGIC  = 8'b0000_0100,
		PH_EXTLEN = 8'b0000_1000,
		PH_EXT    = 8'b0001_0000,
		PH_SIZE   = 8'b0010_0000,
		PH_DATA   = 8'b0100_0000,
		PH_STOP   = 8'b1000_0000
	} phase_t;

	// one input transaction
	typedef struct packed {
		logic [7:0] image_byte;
		logic       start_req;
	} item_t;

	// one result transaction
	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic        last;
	} result_t;

endpackage

// File: src/lssd_front.sv
// lssd_front: input side, accepts image bytes into a short queue
// depends on lssd_pkg
module lssd_front import lssd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] image_byte,
	input  logic       start_req,
	output logic       item_valid,
	output item_t      item,
	input  logic       item_take
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_take && item_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= '{image_byte: image_byte, start_req: start_req};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/lssd_result_queue.sv
// lssd_result_queue: output side, holds decoded results until popped
// depends on lssd_pkg
module lssd_result_queue import lssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  result_t     wr_data,
	output logic        wr_full,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [31:0] value,
	output logic        last
);

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;
	result_t           head;

	assign wr_full = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = wr_en && !wr_full;
	assign do_pop  = pop && !empty;

	// oldest result on the ports
	assign head  = mem_q[rd_ptr_q];
	assign kind  = head.kind;
	assign value = head.value;
	assign last  = head.last;

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/lssd_decode.sv
// lssd_decode: back part, frame decoder state machine and config registers
// depends on lssd_pkg
module lssd_decode import lssd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	input  item_t                 item,
	output logic                  item_take,
	input  logic                  res_full,
	output logic                  res_valid,
	output result_t               res
);

	logic [63:0] magic_word_q;
	logic [3:0]  magic_length_q;
	phase_t      phase_q;
	logic [31:0] bit_shift_q;
	logic [5:0]  bit_count_q;
	logic [31:0] item_count_q;
	logic [31:0] ext_length_q;
	logic [31:0] data_length_q;
	logic        magic_ok_q;

	phase_t      ph, ph_n;
	logic [31:0] sh, sh_n;
	logic [5:0]  bc, bc_n;
	logic [31:0] ic, ic_n;
	logic [31:0] el, el_n;
	logic [31:0] dl, dl_n;
	logic        ok, ok_n;

	logic [31:0] g_shift;
	logic [5:0]  g_cnt;
	logic [31:0] ic_inc;
	logic [3:0]  mlen;
	logic [3:0]  pos_full;
	logic [2:0]  pos;
	logic [7:0]  expect_byte;
	logic [31:0] len_clip;

	assign cfg_ready = 1'b1;
	assign item_take = item_valid && !res_full;

	// signature length clamped to 1..8
	always_comb begin
		if (magic_length_q == 4'd0) begin
			mlen = 4'd1;
		end else if (magic_length_q > 4'(MAGIC_MAX)) begin
			mlen = 4'(MAGIC_MAX);
		end else begin
			mlen = magic_length_q;
		end
	end

	// state seen by this byte, with a start request restarting the frame
	always_comb begin
		if (item.start_req) begin
			ph = (HEADER_BYTES == 0) ? PH_MAGIC : PH_HEADER;
			sh = '0;
			bc = '0;
			ic = '0;
			el = '0;
			dl = '0;
			ok = 1'b1;
		end else begin
			ph = phase_q;
			sh = bit_shift_q;
			bc = bit_count_q;
			ic = item_count_q;
			el = ext_length_q;
			dl = data_length_q;
			ok = magic_ok_q;
		end
	end

	// shared datapath pieces
	assign g_shift     = {sh[30:0], item.image_byte[0]};
	assign g_cnt       = bc + 6'd1;
	assign ic_inc      = ic + 32'd1;
	assign pos_full    = mlen - 4'd1 - {1'b0, ic[2:0]};
	assign pos         = pos_full[2:0];
	assign expect_byte = magic_word_q[{pos, 3'b000} +: 8];
	assign len_clip    = g_shift[31] ? 32'd0 : g_shift;

	// next state and result for one byte
	always_comb begin
		ph_n      = ph;
		sh_n      = sh;
		bc_n      = bc;
		ic_n      = ic;
		el_n      = el;
		dl_n      = dl;
		ok_n      = ok;
		res_valid = 1'b0;
		res       = '{kind: KIND_EXT_LEN, value: 32'd0, last: 1'b0};
		case (ph)
			PH_HEADER: begin
				ic_n = ic_inc;
				if (ic_inc >= 32'(HEADER_BYTES)) begin
					ic_n = '0;
					ph_n = PH_MAGIC;
				end
			end
			PH_MAGIC: begin
				sh_n = g_shift;
				bc_n = g_cnt;
				if (g_cnt >= 6'(BYTE_BITS)) begin
					bc_n = '0;
					sh_n = '0;
					if (g_shift[7:0] != expect_byte) begin
						ok_n = 1'b0;
					end
					ic_n = ic_inc;
					if (ic_inc >= {28'd0, mlen}) begin
						ic_n = '0;
						if (!ok_n) begin
							ph_n      = PH_STOP;
							res_valid = 1'b1;
							res       = '{kind: KIND_MISMATCH, value: 32'd0, last: 1'b1};
						end else begin
							ph_n = PH_EXTLEN;
						end
					end
				end
			end
			PH_EXTLEN: begin
				sh_n = g_shift;
				bc_n = g_cnt;
				if (g_cnt >= 6'(WORD_BITS)) begin
					bc_n      = '0;
					sh_n      = '0;
					el_n      = len_clip;
					ic_n      = '0;
					ph_n      = (len_clip != 32'd0) ? PH_EXT : PH_SIZE;
					res_valid = 1'b1;
					res       = '{kind: KIND_EXT_LEN, value: g_shift, last: 1'b0};
				end
			end
			PH_EXT: begin
				sh_n = g_shift;
				bc_n = g_cnt;
				if (g_cnt >= 6'(BYTE_BITS)) begin
					bc_n = '0;
					sh_n = '0;
					ic_n = ic_inc;
					if (ic_inc >= el) begin
						ic_n = '0;
						ph_n = PH_SIZE;
					end
					res_valid = 1'b1;
					res       = '{kind: KIND_EXT_BYTE, value: {24'd0, g_shift[7:0]},
						last: 1'b0};
				end
			end
			PH_SIZE: begin
				sh_n = g_shift;
				bc_n = g_cnt;
				if (g_cnt >= 6'(WORD_BITS)) begin
					bc_n      = '0;
					sh_n      = '0;
					dl_n      = len_clip;
					ic_n      = '0;
					ph_n      = (len_clip != 32'd0) ? PH_DATA : PH_STOP;
					res_valid = 1'b1;
					res       = '{kind: KIND_FILE_SIZE, value: g_shift,
						last: (len_clip == 32'd0)};
				end
			end
			PH_DATA: begin
				sh_n = g_shift;
				bc_n = g_cnt;
				if (g_cnt >= 6'(BYTE_BITS)) begin
					bc_n = '0;
					sh_n = '0;
					ic_n = ic_inc;
					res_valid = 1'b1;
					res       = '{kind: KIND_DATA_BYTE, value: {24'd0, g_shift[7:0]},
						last: 1'b0};
					if (ic_inc >= dl) begin
						ic_n     = '0;
						ph_n     = PH_STOP;
						res.last = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		// nothing is produced without a transaction
		if (!item_take) begin
			res_valid = 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q   <= 64'd8994;
			magic_length_q <= 4'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAGIC_WORD:   magic_word_q   <= cfg_data;
				CFG_MAGIC_LENGTH: magic_length_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_shift_q   <= '0;
			bit_count_q   <= '0;
			item_count_q  <= '0;
			ext_length_q  <= '0;
			data_length_q <= '0;
			magic_ok_q    <= 1'b1;
		end else if (item_take) begin
			phase_q       <= ph_n;
			bit_shift_q   <= sh_n;
			bit_count_q   <= bc_n;
			item_count_q  <= ic_n;
			ext_length_q  <= el_n;
			data_length_q <= dl_n;
			magic_ok_q    <= ok_n;
		end
	end

endmodule

// File: src/lsb_stego_stream_decoder_unit.sv
// lsb_stego_stream_decoder_unit: top level of the lsb stego stream decoder
// depends on lssd_pkg, lssd_front, lssd_decode, lssd_result_queue
// throughput: one image byte per cycle while the result queue is not full; the decoder step is combinational
// path: a result is poppable once its last carrier byte has passed the input queue
// and then the result queue; a full result queue stalls the decoder
// reset: arst_n clears queues and decoder to idle, config to magic 8994, length 2
module lsb_stego_stream_decoder_unit import lssd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            image_byte,
	input  logic                  start_req,
	output logic                  empty,
	input  logic                  pop,
	output logic [2:0]            kind,
	output logic [31:0]           value,
	output logic                  last,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic    item_valid;
	item_t   item;
	logic    item_take;
	logic    res_full;
	logic    res_valid;
	result_t res;

	// input queue
	lssd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.image_byte (image_byte),
		.start_req  (start_req),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take)
	);

	// frame decoder
	lssd_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item       (item),
		.item_take  (item_take),
		.res_full   (res_full),
		.res_valid  (res_valid),
		.res        (res)
	);

	// result queue
	lssd_result_queue u_result_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.wr_full (res_full),
		.empty   (empty),
		.pop     (pop),
		.kind    (kind),
		.value   (value),
		.last    (last)
	);

endmodule

// File: tb/sv/lssd_checker.sv
// lssd_checker: watches the image byte, result and register channels of the
// lsb stego stream decoder, predicts every result and compares it field by field
// depends on lssd_pkg
`timescale 1ns / 1ps
module lssd_checker import lssd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  full,
	input  logic [7:0]            image_byte,
	input  logic                  start_req,
	input  logic                  empty,
	input  logic                  pop,
	input  logic [2:0]            kind,
	input  logic [31:0]           value,
	input  logic                  last,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           fail_count,
	output int unsigned           pending_count,
	output int unsigned           popped_count
);

	// register copies
	logic [63:0] magic_word_q;
	logic [3:0]  magic_len_q;

	// decoder state copy
	phase_t      ph;
	logic [31:0] shreg;
	logic [5:0]  nbits;
	logic [31:0] nitems;
	logic [31:0] ext_len;
	logic [31:0] data_len;
	logic        sig_ok;

	result_t     decoded_q[$];
	int unsigned errs;
	int unsigned seen;

	// signature bytes in use, clamped to 1..8
	function automatic int unsigned sig_bytes_used();
		if (magic_len_q == 4'd0)
			return 1;
		if (magic_len_q > MAGIC_MAX)
			return MAGIC_MAX;
		return magic_len_q;
	endfunction

	// shift in one carrier bit, report a completed field of w bits
	function automatic bit shift_in(input logic [7:0] b, input int unsigned w);
		shreg = {shreg[30:0], b[0]};
		nbits = nbits + 6'd1;
		if (nbits >= w) begin
			nbits = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic queue_result(input kind_t k, input logic [31:0] v, input logic l);
		result_t r;
		r.kind  = k;
		r.value = v;
		r.last  = l;
		decoded_q.push_back(r);
	endtask

	// one image byte through the frame decoder
	task automatic decode_carrier_byte(input logic [7:0] b, input logic s);
		logic [31:0] v;
		logic [7:0]  want;
		int unsigned n;
		int unsigned pos;
		if (s) begin
			ph       = (HEADER_BYTES == 0) ? PH_MAGIC : PH_HEADER;
			shreg    = '0;
			nbits    = '0;
			nitems   = '0;
			ext_len  = '0;
			data_len = '0;
			sig_ok   = 1'b1;
		end
		case (ph)
			PH_HEADER: begin
				nitems++;
				if (nitems >= HEADER_BYTES) begin
					nitems = '0;
					ph = PH_MAGIC;
				end
			end
			PH_MAGIC: begin
				if (shift_in(b, BYTE_BITS)) begin
					n    = sig_bytes_used();
					pos  = n - 1 - (nitems & 7);
					want = 8'(magic_word_q >> (8 * (pos & 7)));
					if (shreg[7:0] != want)
						sig_ok = 1'b0;
					shreg = '0;
					nitems++;
					if (nitems >= n) begin
						nitems = '0;
						if (!sig_ok) begin
							ph = PH_STOP;
							queue_result(KIND_MISMATCH, '0, 1'b1);
						end else begin
							ph = PH_EXTLEN;
						end
					end
				end
			end
			PH_EXTLEN: begin
				if (shift_in(b, WORD_BITS)) begin
					v       = shreg;
					shreg   = '0;
					ext_len = v[31] ? '0 : v;
					nitems  = '0;
					ph      = (ext_len != 0) ? PH_EXT : PH_SIZE;
					queue_result(KIND_EXT_LEN, v, 1'b0);
				end
			end
			PH_EXT: begin
				if (shift_in(b, BYTE_BITS)) begin
					v     = {24'd0, shreg[7:0]};
					shreg = '0;
					nitems++;
					if (nitems >= ext_len) begin
						nitems = '0;
						ph = PH_SIZE;
					end
					queue_result(KIND_EXT_BYTE, v, 1'b0);
				end
			end
			PH_SIZE: begin
				if (shift_in(b, WORD_BITS)) begin
					v        = shreg;
					shreg    = '0;
					data_len = v[31] ? '0 : v;
					nitems   = '0;
					ph       = (data_len != 0) ? PH_DATA : PH_STOP;
					queue_result(KIND_FILE_SIZE, v, data_len == 0);
				end
			end
			PH_DATA: begin
				if (shift_in(b, BYTE_BITS)) begin
					v     = {24'd0, shreg[7:0]};
					shreg = '0;
					nitems++;
					if (nitems >= data_len) begin
						nitems = '0;
						ph = PH_STOP;
						queue_result(KIND_DATA_BYTE, v, 1'b1);
					end else begin
						queue_result(KIND_DATA_BYTE, v, 1'b0);
					end
				end
			end
			default: ;
		endcase
	endtask

	// register writes, image bytes and results, in that order per edge
	always @(posedge clk or negedge arst_n) begin
		result_t due;
		if (!arst_n) begin
			magic_word_q = 64'd8994;
			magic_len_q  = 4'd2;
			ph           = PH_IDLE;
			shreg        = '0;
			nbits        = '0;
			nitems       = '0;
			ext_len      = '0;
			data_len     = '0;
			sig_ok       = 1'b1;
			decoded_q.delete();
			errs         = 0;
			seen         = 0;
			fail_count    <= 0;
			pending_count <= 0;
			popped_count  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MAGIC_WORD)
					magic_word_q = cfg_data;
				else if (cfg_index == CFG_MAGIC_LENGTH)
					magic_len_q = cfg_data[3:0];
			end
			if (push && !full)
				decode_carrier_byte(image_byte, start_req);
			if (pop && !empty) begin
				seen++;
				if (decoded_q.size() == 0) begin
					$error("result with nothing pending: kind %0d value %0h last %0b",
						kind, value, last);
					errs++;
				end else begin
					due = decoded_q.pop_front();
					if (kind !== due.kind) begin
						$error("kind: expected %0d, got %0d", due.kind, kind);
						errs++;
					end
					if (value !== due.value) begin
						$error("value: expected %0h, got %0h", due.value, value);
						errs++;
					end
					if (last !== due.last) begin
						$error("last: expected %0b, got %0b", due.last, last);
						errs++;
					end
				end
			end
			fail_count    <= errs;
			pending_count <= decoded_q.size();
			popped_count  <= seen;
		end
	end

endmodule

// File: tb/sv/tb_top.sv
// tb_top: stimulus and verdict for lsb_stego_stream_decoder_unit
// depends on lssd_pkg, lssd_checker and the decoder rtl
`timescale 1ns / 1ps
module tb_top;
	import lssd_pkg::*;

	localparam int unsigned ITEM_TARGET   = 1150;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned DRAIN_CYCLES  = 8;
	localparam int unsigned IDLE_PCT      = 16;
	localparam int unsigned MAX_RUN_BYTES = 4;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic [7:0]            image_byte;
	logic                  start_req;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [2:0]            kind;
	logic [31:0]           value;
	logic                  last;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int unsigned fail_count;
	int unsigned pending_count;
	int unsigned popped_count;
	int unsigned cycle_count = 0;
	int unsigned frame_count = 0;
	int unsigned item_count  = 0;
	bit          steady      = 1'b0;

	// signature setup as last written, used to build frames
	logic [63:0] sig_word = 64'd8994;
	logic [3:0]  sig_len  = 4'd2;

	lsb_stego_stream_decoder_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.image_byte (image_byte),
		.start_req  (start_req),
		.empty      (empty),
		.pop        (pop),
		.kind       (kind),
		.value      (value),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	lssd_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.image_byte    (image_byte),
		.start_req     (start_req),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.value         (value),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.popped_count  (popped_count)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped at cycle limit %0d", CYCLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side stalls
	always @(posedge clk) begin
		if (arst_n)
			pop <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// one image byte transaction, with a random gap ahead of it
	task automatic send_byte(input logic [7:0] b, input logic s);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push       <= 1'b1;
		image_byte <= b;
		start_req  <= s;
		do @(posedge clk); while (full);
	endtask

	// bytes with no start flag, outside any frame
	task automatic send_noise(input int unsigned cnt);
		for (int i = 0; i < cnt; i++)
			send_byte(8'($urandom), 1'b0);
	endtask

	function automatic void add_bits(ref bit q[$], input logic [31:0] v, input int unsigned w);
		for (int k = w - 1; k >= 0; k--)
			q.push_back(v[k]);
	endfunction

	// one image: header, signature, lengths and payload; cut > 0 stops after
	// that many bytes so the next start abandons the frame
	task automatic send_frame(input bit corrupt, input logic [31:0] ext_word,
			input logic [31:0] size_word, input int unsigned cut);
		bit          carrier[$];
		int unsigned n;
		int unsigned bad;
		int unsigned ext_n;
		int unsigned data_n;
		int unsigned sent;
		logic [7:0]  sb;
		n = (sig_len == 4'd0) ? 1 : (sig_len > MAGIC_MAX) ? MAGIC_MAX : sig_len;
		bad = corrupt ? $urandom_range(0, n - 1) : MAGIC_MAX;
		for (int i = 0; i < n; i++) begin
			sb = 8'(sig_word >> (8 * (n - 1 - i)));
			if (i == bad)
				sb ^= 8'($urandom_range(1, 255));
			add_bits(carrier, sb, BYTE_BITS);
		end
		add_bits(carrier, ext_word, WORD_BITS);
		ext_n = ext_word[31] ? 0 : ext_word;
		for (int i = 0; i < ext_n && i < MAX_RUN_BYTES; i++)
			add_bits(carrier, $urandom, BYTE_BITS);
		// a huge extension never reaches the size field
		if (ext_n <= MAX_RUN_BYTES) begin
			add_bits(carrier, size_word, WORD_BITS);
			data_n = size_word[31] ? 0 : size_word;
			for (int i = 0; i < data_n && i < MAX_RUN_BYTES; i++)
				add_bits(carrier, $urandom, BYTE_BITS);
		end
		sent = 0;
		for (int i = 0; i < HEADER_BYTES; i++) begin
			if (cut != 0 && sent >= cut)
				break;
			send_byte(8'($urandom), i == 0);
			sent++;
		end
		foreach (carrier[j]) begin
			if (cut != 0 && sent >= cut)
				break;
			send_byte({7'($urandom), carrier[j]}, HEADER_BYTES == 0 && j == 0);
			sent++;
		end
		item_count += sent;
		frame_count++;
	endtask

	// stop sending and let every pending result drain
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// both registers back to back, block idle
	task automatic configure(input logic [63:0] word, input logic [3:0] len);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MAGIC_WORD;
		cfg_data  <= word;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_MAGIC_LENGTH;
		cfg_data  <= {$urandom, 28'($urandom), len};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sig_word = word;
		sig_len  = len;
	endtask

	initial begin
		int unsigned r;
		int unsigned k;
		arst_n     = 1'b0;
		push       = 1'b0;
		image_byte = '0;
		start_req  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_MAGIC_WORD;
		cfg_data   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset signature, edge lengths, abandoned frames
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		// no idling on either side across two full frames
		steady <= 1'b1;
		send_frame(1'b0, 32'd2, 32'd3, 0);
		send_noise(3);
		send_frame(1'b0, 32'hffff_ffff, 32'h8000_0000, 0);
		steady <= 1'b0;
		send_frame(1'b0, 32'h7fff_ffff, 32'd0, 0);
		send_frame(1'b0, 32'd1, 32'd2, 10);

		// directed: signature extremes, out of range lengths
		configure(64'hffff_ffff_ffff_ffff, 4'd8);
		send_frame(1'b1, 32'd0, 32'd1, 0);
		configure({$urandom, $urandom}, 4'd0);
		send_frame(1'b0, 32'd1, 32'd1, 0);
		configure({$urandom, $urandom}, 4'd15);
		send_frame(1'b0, 32'd0, 32'd1, 0);

		// random frames, new signature every few frames
		k = 0;
		while (item_count < ITEM_TARGET) begin
			if (k % 4 == 0)
				configure({$urandom, $urandom}, 4'($urandom_range(1, MAGIC_MAX)));
			r = $urandom_range(99);
			if (r < 70)
				send_frame(1'b0, $urandom_range(0, 3), $urandom_range(0, 6), 0);
			else if (r < 80)
				send_frame(1'b1, $urandom_range(0, 3), $urandom_range(0, 6), 0);
			else if (r < 90)
				send_frame(1'b0, $urandom_range(0, 3), $urandom_range(1, 6),
					$urandom_range(1, 200));
			else
				send_frame(1'b0, {1'b1, 31'($urandom)}, {1'b1, 31'($urandom)}, 0);
			if ($urandom_range(3) == 0)
				send_noise($urandom_range(1, 6));
			k++;
		end

		settle();
		$display("%0d frames, %0d image bytes, %0d results checked over several signature setups",
			frame_count, item_count, popped_count);
		if (fail_count == 0 && pending_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
src/lssd_pkg.sv
src/lssd_front.sv
src/lssd_result_queue.sv
src/lssd_decode.sv
src/lsb_stego_stream_decoder_unit.sv
tb/sv/lssd_checker.sv
tb/sv/tb_top.sv
